[sv/sdist_pkg.sv]
// Shared constants, queue entry type and a saturation helper for the selectable vector distance block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package sdist_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int COORD_BITS   = 16;
  localparam int DIFF_BITS    = COORD_BITS;
  localparam int SQ_BITS      = 2 * DIFF_BITS;
  localparam int ACC_BITS     = 42;
  localparam int DIST_BITS    = 26;
  localparam int LEN_BITS     = 11;
  localparam int METRIC_BITS  = 2;
  localparam int CFG_IDX_BITS = 1;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_AW      = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_METRIC = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH = 1'd1;

  // Metric codes; the unused code behaves as the maximum
  localparam logic [METRIC_BITS-1:0] METRIC_L1   = 2'd0;
  localparam logic [METRIC_BITS-1:0] METRIC_L2   = 2'd1;
  localparam logic [METRIC_BITS-1:0] METRIC_LINF = 2'd2;

  // One classified pair, as handed from the front end to the back end
  typedef struct packed {
    logic [SQ_BITS-1:0] val;
    logic               is_max;
    logic               is_l2;
    logic               last;
  } sdist_entry_t;

  function automatic logic [DIST_BITS-1:0] sat_dist(input logic [ACC_BITS-1:0] v);
    logic [DIST_BITS-1:0] r;
    if (|v[ACC_BITS-1:DIST_BITS]) begin
      r = '1;
    end else begin
      r = v[DIST_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[sv/sdist_front.sv]
// Front end: takes coordinate pairs, forms |a-b| or its square, marks the last pair.
// Depends on sdist_pkg.
`timescale 1ns / 1ps

module sdist_front import sdist_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_BITS-1:0]  coord_a_i,
  input  logic [COORD_BITS-1:0]  coord_b_i,
  input  logic [METRIC_BITS-1:0] metric_i,
  input  logic [LEN_BITS-1:0]    length_i,
  input  logic                   full_i,
  output logic                   push_o,
  output sdist_entry_t           entry_o
);

  logic [LEN_BITS-1:0]   pair_cnt_q, pair_cnt_d;
  logic [LEN_BITS-1:0]   len_eff;
  logic [LEN_BITS:0]     cnt_inc;
  logic [COORD_BITS:0]   diff;
  logic [COORD_BITS:0]   mag;
  logic [DIFF_BITS-1:0]  ad;
  logic [SQ_BITS-1:0]    sq;
  logic                  is_l2;
  logic                  is_max;
  logic                  last;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    diff = {coord_a_i[COORD_BITS-1], coord_a_i} - {coord_b_i[COORD_BITS-1], coord_b_i};
    mag  = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
    ad   = mag[DIFF_BITS-1:0];
    sq   = SQ_BITS'(ad) * SQ_BITS'(ad);
  end

  assign is_l2  = (metric_i == METRIC_L2);
  assign is_max = (metric_i != METRIC_L1) && !is_l2;

  // clamp length into 1..MAX_DIM
  always_comb begin
    if (length_i == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (length_i > LEN_BITS'(MAX_DIM)) begin
      len_eff = LEN_BITS'(MAX_DIM);
    end else begin
      len_eff = length_i;
    end
  end

  assign cnt_inc = {1'b0, pair_cnt_q} + 1'b1;
  assign last    = (cnt_inc >= {1'b0, len_eff});

  always_comb begin
    entry_o.val    = is_l2 ? sq : SQ_BITS'(ad);
    entry_o.is_max = is_max;
    entry_o.is_l2  = is_l2;
    entry_o.last   = last;
  end

  always_comb begin
    pair_cnt_d = pair_cnt_q;
    if (push_o) begin
      pair_cnt_d = last ? '0 : cnt_inc[LEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_cnt_q <= '0;
    end else begin
      pair_cnt_q <= pair_cnt_d;
    end
  end

endmodule

[sv/sdist_fifo.sv]
// Short queue of classified pairs between the front end and the back end.
// Depends on sdist_pkg.
`timescale 1ns / 1ps

module sdist_fifo import sdist_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  sdist_entry_t entry_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         valid_o,
  output sdist_entry_t entry_o
);

  sdist_entry_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     count_q, count_d;

  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[sv/sdist_back.sv]
// Back end: accumulates sum or maximum, runs the bit-serial square root, holds the result.
// Depends on sdist_pkg.
`timescale 1ns / 1ps

module sdist_back import sdist_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sdist_entry_t         entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DIST_BITS-1:0] distance_o
);

  localparam logic ST_ACC  = 1'b0;
  localparam logic ST_ROOT = 1'b1;

  logic                 state_q, state_d;
  logic [ACC_BITS-1:0]  acc_q, acc_d;
  logic [ACC_BITS-1:0]  rad_q, rad_d;
  logic [ACC_BITS-1:0]  res_q, res_d;
  logic [ACC_BITS-1:0]  bit_q, bit_d;
  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic                 out_valid_q, out_valid_d;

  logic                 out_free;
  logic                 load_out;
  logic [ACC_BITS:0]    acc_sum;
  logic [ACC_BITS-1:0]  acc_add;
  logic [ACC_BITS-1:0]  val_ext;
  logic [ACC_BITS-1:0]  acc_max;
  logic [ACC_BITS-1:0]  acc_next;
  logic [ACC_BITS:0]    trial;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    val_ext  = ACC_BITS'(entry_i.val);
    acc_sum  = {1'b0, acc_q} + {1'b0, val_ext};
    acc_add  = acc_sum[ACC_BITS] ? '1 : acc_sum[ACC_BITS-1:0];
    acc_max  = (val_ext > acc_q) ? val_ext : acc_q;
    acc_next = entry_i.is_max ? acc_max : acc_add;
    trial    = {1'b0, res_q} + {1'b0, bit_q};
  end

  always_comb begin
    state_d  = state_q;
    acc_d    = acc_q;
    rad_d    = rad_q;
    res_d    = res_q;
    bit_d    = bit_q;
    dist_d   = dist_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_ACC: begin
        // a last pair that finishes L1 or maximum needs the output register
        if (valid_i && (!entry_i.last || entry_i.is_l2 || out_free)) begin
          pop_o = 1'b1;
          if (entry_i.last) begin
            acc_d = '0;
            if (entry_i.is_l2) begin
              rad_d   = acc_next;
              res_d   = '0;
              bit_d   = ACC_BITS'(1) << (ACC_BITS - 2);
              state_d = ST_ROOT;
            end else begin
              load_out = 1'b1;
              dist_d   = sat_dist(acc_next);
            end
          end else begin
            acc_d = acc_next;
          end
        end
      end
      ST_ROOT: begin
        if (bit_q != '0) begin
          if ({1'b0, rad_q} >= trial) begin
            rad_d = rad_q - trial[ACC_BITS-1:0];
            res_d = (res_q >> 1) + bit_q;
          end else begin
            res_d = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else if (out_free) begin
          load_out = 1'b1;
          dist_d   = sat_dist(res_q);
          state_d  = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    dist_q <= dist_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/selectable_vector_distance.sv]
// Top level of the selectable vector distance block: configuration registers and wiring.
// Depends on sdist_pkg, sdist_front, sdist_fifo and sdist_back.
`timescale 1ns / 1ps

// Streams one signed Q8.8 coordinate pair per cycle while in_stall_o is low and
// returns one unsigned Q18.8 distance per vector; the length register sets the pairs
// per vector (0 counts as 1, above 1024 as 1024). The metric register picks L1 (0),
// Euclidean with floored square root (1) or the largest absolute difference (2, and 3).
// Pairs are taken at one per cycle through a two-entry queue while it is not full; an
// L1 or maximum result is loaded into the output register when the last pair is popped
// and that register is free. An L2 result is formed in the bit-serial square root, one
// result bit per cycle, during which the back end takes no pairs. Write the configuration
// only while no vector result is outstanding.
module selectable_vector_distance import sdist_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [LEN_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [COORD_BITS-1:0]   coord_a_i,
  input  logic [COORD_BITS-1:0]   coord_b_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DIST_BITS-1:0]    distance_o
);

  logic [METRIC_BITS-1:0] metric_q, metric_d;
  logic [LEN_BITS-1:0]    length_q, length_d;

  logic         push;
  logic         pop;
  logic         full;
  logic         q_valid;
  sdist_entry_t push_entry;
  sdist_entry_t pop_entry;

  always_comb begin
    metric_d = metric_q;
    length_d = length_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_METRIC: metric_d = cfg_data_i[METRIC_BITS-1:0];
        CFG_LENGTH: length_d = cfg_data_i;
        default: begin
          metric_d = metric_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= METRIC_L1;
      length_q <= LEN_BITS'(1);
    end else begin
      metric_q <= metric_d;
      length_q <= length_d;
    end
  end

  sdist_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .coord_a_i  (coord_a_i),
    .coord_b_i  (coord_b_i),
    .metric_i   (metric_q),
    .length_i   (length_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sdist_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  sdist_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o)
  );

endmodule

[sv/sdist_checker.sv]
// Port-level checks for selectable_vector_distance, attached by a bind statement.
// Depends on sdist_pkg and the top level's port list.
`timescale 1ns / 1ps

module sdist_checker import sdist_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [COORD_BITS-1:0]   coord_a_i,
  input logic [COORD_BITS-1:0]   coord_b_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [DIST_BITS-1:0]    distance_o
);

  // a stalled result stays and keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o))
    else $error("distance changed or dropped while stalled");

  // a stalled input item stays and keeps its fields
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(coord_a_i) && $stable(coord_b_i))
    else $error("input item changed or dropped while stalled");

  // the queue only fills through an accepted item
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised without an accepted item");

  // leaving reset, the queue is empty and no result is pending
  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_stall_o && !out_valid_o)
    else $error("block not clean after reset");

endmodule

bind selectable_vector_distance sdist_checker u_sdist_checker (.*);
